@@ hdl/decrypt_rle_decimal_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// decrypt_rle_decimal_decoder_assert
// assertion macros shared by the decoder modules
// ----------------------------------------------------------------------------
`ifndef DECRYPT_RLE_DECIMAL_DECODER_ASSERT_SVH
`define DECRYPT_RLE_DECIMAL_DECODER_ASSERT_SVH

// checked only outside reset
`define DRD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// checked on every edge, reset included
`define DRD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ hdl/drd_pkg.sv @@
// ----------------------------------------------------------------------------
// drd_pkg
// types and constants of the decrypting run-length decoder
// ----------------------------------------------------------------------------
`default_nettype none

package drd_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROT_W       = 3;
  localparam int MAX_RUN     = 64;
  localparam int COUNT_W     = $clog2(MAX_RUN + 1);
  localparam int PROD_W      = COUNT_W + 4;
  localparam int DIGIT_W     = 4;
  localparam int REG_IDX_W   = 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    STATUS_BYTE = 2'd0,
    STATUS_OK   = 2'd1,
    STATUS_ERR  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_RUN = 1'b0,
    CMD_END = 1'b1
  } cmd_kind_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROTATE = 1'b0,
    REG_XOR    = 1'b1
  } reg_index_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  sym;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } fifo_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fifo_rd_t;

endpackage

`default_nettype wire

@@ hdl/drd_if.sv @@
// ----------------------------------------------------------------------------
// drd_if
// handshake channels of the decrypting run-length decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface drd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [drd_pkg::BYTE_W-1:0]  data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface drd_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [drd_pkg::BYTE_W-1:0]  out_byte;
  logic                        run_last;
  modport source (output valid, status, out_byte, run_last, input ready);
  modport sink (input valid, status, out_byte, run_last, output ready);
endinterface

interface drd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [drd_pkg::REG_IDX_W-1:0] index;
  logic [drd_pkg::BYTE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/drd_front.sv @@
// ----------------------------------------------------------------------------
// drd_front
// decrypts message bytes, parses counts and symbols, issues run and end commands
// ----------------------------------------------------------------------------
`default_nettype none

module drd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  drd_in_if.sink                          in_ch,
  input  wire logic [drd_pkg::ROT_W-1:0]  rotate_amount,
  input  wire logic [drd_pkg::BYTE_W-1:0] xor_key,
  input  wire logic                       fifo_full,
  output drd_pkg::fifo_wr_t               fifo_wr
);

  logic [drd_pkg::COUNT_W-1:0]  run_count;
  logic [drd_pkg::COUNT_W-1:0]  run_count_next;
  logic                         digits_seen;
  logic                         digits_seen_next;
  logic                         error_seen;
  logic                         error_seen_next;
  logic                         accept;
  logic [drd_pkg::BYTE_W-1:0]   mixed;
  logic [2*drd_pkg::BYTE_W-1:0] doubled;
  logic [drd_pkg::BYTE_W-1:0]   plain;
  logic                         is_digit;
  logic [drd_pkg::PROD_W-1:0]   acc;

  assign in_ch.ready = !fifo_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // xor then rotate right within the byte
  assign mixed   = in_ch.data_byte ^ xor_key;
  assign doubled = {mixed, mixed} >> rotate_amount;
  assign plain   = doubled[drd_pkg::BYTE_W-1:0];

  always_comb begin
    is_digit = plain inside {[drd_pkg::CHAR_ZERO:drd_pkg::CHAR_NINE]};
  end

  // count times ten plus the new digit
  assign acc = ({{(drd_pkg::PROD_W-drd_pkg::COUNT_W){1'b0}}, run_count} << 3)
             + ({{(drd_pkg::PROD_W-drd_pkg::COUNT_W){1'b0}}, run_count} << 1)
             + {{(drd_pkg::PROD_W-drd_pkg::DIGIT_W){1'b0}}, plain[drd_pkg::DIGIT_W-1:0]};

  always_comb begin
    run_count_next     = run_count;
    digits_seen_next   = digits_seen;
    error_seen_next    = error_seen;
    fifo_wr.push       = 1'b0;
    fifo_wr.cmd.kind   = drd_pkg::CMD_RUN;
    fifo_wr.cmd.sym    = plain;
    fifo_wr.cmd.count  = run_count;
    fifo_wr.cmd.status = drd_pkg::STATUS_BYTE;
    if (accept) begin
      if (in_ch.action) begin
        fifo_wr.push       = 1'b1;
        fifo_wr.cmd.kind   = drd_pkg::CMD_END;
        fifo_wr.cmd.sym    = '0;
        fifo_wr.cmd.status = (error_seen || digits_seen) ? drd_pkg::STATUS_ERR
                                                         : drd_pkg::STATUS_OK;
        run_count_next     = '0;
        digits_seen_next   = 1'b0;
        error_seen_next    = 1'b0;
      end else if (!error_seen) begin
        if (is_digit) begin
          digits_seen_next = 1'b1;
          if (acc > drd_pkg::PROD_W'(drd_pkg::MAX_RUN)) begin
            error_seen_next = 1'b1;
            run_count_next  = '0;
          end else begin
            run_count_next = acc[drd_pkg::COUNT_W-1:0];
          end
        end else if (!digits_seen) begin
          error_seen_next = 1'b1;
        end else begin
          fifo_wr.push     = run_count != '0;
          run_count_next   = '0;
          digits_seen_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count   <= '0;
      digits_seen <= 1'b0;
      error_seen  <= 1'b0;
    end else begin
      run_count   <= run_count_next;
      digits_seen <= digits_seen_next;
      error_seen  <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/drd_fifo.sv @@
// ----------------------------------------------------------------------------
// drd_fifo
// short command queue between parser and run emitter
// ----------------------------------------------------------------------------
`default_nettype none

`include "decrypt_rle_decimal_decoder_assert.svh"

module drd_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  drd_pkg::fifo_wr_t fifo_wr,
  output logic              fifo_full,
  output drd_pkg::fifo_rd_t fifo_rd,
  input  wire logic         pop
);

  drd_pkg::cmd_t                  entries [drd_pkg::FIFO_DEPTH];
  logic [drd_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [drd_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [drd_pkg::FIFO_CNT_W-1:0] fill;
  logic                           do_push;
  logic                           do_pop;

  assign fifo_full     = fill == drd_pkg::FIFO_CNT_W'(drd_pkg::FIFO_DEPTH);
  assign fifo_rd.valid = fill != '0;
  assign fifo_rd.cmd   = entries[rd_ptr];
  assign do_push       = fifo_wr.push && !fifo_full;
  assign do_pop        = pop && fifo_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= fifo_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `DRD_ASSERT_ALWAYS(a_fill_bound, clk, (rst || fill <= drd_pkg::FIFO_CNT_W'(drd_pkg::FIFO_DEPTH)), "queue overfilled")
  `DRD_ASSERT(a_no_push_full, clk, rst, !(fifo_wr.push && fifo_full), "push into full queue")
  `DRD_ASSERT(a_push_grows, clk, rst, (do_push && !do_pop) |=> fill == $past(fill) + 1'b1, "fill did not grow")

endmodule

`default_nettype wire

@@ hdl/drd_back.sv @@
// ----------------------------------------------------------------------------
// drd_back
// expands run and end commands into output transactions through an output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "decrypt_rle_decimal_decoder_assert.svh"

module drd_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  drd_pkg::fifo_rd_t fifo_rd,
  output logic              pop,
  drd_out_if.source         out_ch
);

  logic                        cur_valid;
  drd_pkg::cmd_kind_t          cur_kind;
  logic [drd_pkg::BYTE_W-1:0]  cur_sym;
  logic [drd_pkg::COUNT_W-1:0] cur_left;
  drd_pkg::status_t            cur_status;
  logic                        emit;
  logic                        last;

  assign pop  = fifo_rd.valid && !cur_valid;
  assign emit = cur_valid && (!out_ch.valid || out_ch.ready);
  assign last = (cur_kind == drd_pkg::CMD_END) || (cur_left == drd_pkg::COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (emit && last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind   <= fifo_rd.cmd.kind;
      cur_sym    <= fifo_rd.cmd.sym;
      cur_left   <= fifo_rd.cmd.count;
      cur_status <= fifo_rd.cmd.status;
    end else if (emit) begin
      cur_left <= cur_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.status   <= cur_status;
      out_ch.out_byte <= cur_sym;
      out_ch.run_last <= last;
    end
  end

  `DRD_ASSERT(a_run_nonzero, clk, rst, (cur_valid && cur_kind == drd_pkg::CMD_RUN) |-> cur_left != '0, "empty run held")
  `DRD_ASSERT(a_pop_idle, clk, rst, pop |-> !cur_valid, "pop while busy")
  `DRD_ASSERT(a_end_last, clk, rst, (out_ch.valid && out_ch.status != drd_pkg::STATUS_BYTE) |-> out_ch.run_last, "end result not last")

endmodule

`default_nettype wire

@@ hdl/decrypt_rle_decimal_decoder.sv @@
// ----------------------------------------------------------------------------
// decrypt_rle_decimal_decoder
// decrypting run-length decoder with decimal counts
// ----------------------------------------------------------------------------
// in_ch takes one transaction per message byte (action 0) or end of message
// (action 1). each byte is xored with xor_key and rotated right by
// rotate_amount, then parsed: decimal digits build a count, the next byte is
// the symbol, emitted count times on out_ch with run_last on the final copy.
// an end transaction gives one result: status ok or error, run_last set.
// cfg writes register 0 (rotate_amount) or 1 (xor_key); write only when idle.
// digit and end bytes are taken one per cycle while the command queue has
// room; the emitter takes a new command only after it has finished the current
// one and gives one result per cycle while out_ch does not stall, so sustained
// rate follows the output count. the first result of a symbol or end transaction
// passes the command queue, the emitter register and the output register to out_ch.
// when out_ch stalls the output register holds, the emitter waits and the
// four-entry queue fills before in_ch drops ready.
// synchronous reset clears the parser, queue, emitter and both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module decrypt_rle_decimal_decoder (
  input  wire logic clk,
  input  wire logic rst,
  drd_in_if.sink    in_ch,
  drd_out_if.source out_ch,
  drd_cfg_if.sink   cfg
);

  logic [drd_pkg::ROT_W-1:0]  rotate_amount;
  logic [drd_pkg::BYTE_W-1:0] xor_key;
  drd_pkg::fifo_wr_t          fifo_wr;
  drd_pkg::fifo_rd_t          fifo_rd;
  logic                       fifo_full;
  logic                       pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_amount <= '0;
      xor_key       <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (drd_pkg::reg_index_t'(cfg.index))
        drd_pkg::REG_ROTATE: rotate_amount <= cfg.data[drd_pkg::ROT_W-1:0];
        drd_pkg::REG_XOR:    xor_key <= cfg.data;
        default:             xor_key <= xor_key;
      endcase
    end
  end

  drd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .rotate_amount (rotate_amount),
    .xor_key       (xor_key),
    .fifo_full     (fifo_full),
    .fifo_wr       (fifo_wr)
  );

  drd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .fifo_wr   (fifo_wr),
    .fifo_full (fifo_full),
    .fifo_rd   (fifo_rd),
    .pop       (pop)
  );

  drd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .fifo_rd (fifo_rd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ bench/tb_decrypt_rle_decimal_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_decrypt_rle_decimal_decoder
// self-checking bench for the decrypting run-length decoder
// ----------------------------------------------------------------------------
// a short directed table covers the corner cases of the parser (empty message,
// zero count, zero byte, longest run, symbol without count, count overflow,
// end after digits), then random messages run under several register settings
// and idle patterns. plain text is encrypted with the current key and
// rotation before it is sent. every accepted input transaction is run through
// a local decoder model whose results (for a directed end, the table's status)
// are compared field by field, in order, with each accepted output transaction.
// ----------------------------------------------------------------------------

module tb_decrypt_rle_decimal_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 35;

  typedef struct packed {
    drd_pkg::status_t           status;
    logic [drd_pkg::BYTE_W-1:0] sym;
    logic                       last;
  } result_t;

  typedef struct {
    drd_pkg::cmd_kind_t         kind;
    logic [drd_pkg::BYTE_W-1:0] plain;
    bit                         typed;
    drd_pkg::status_t           typed_status;
  } step_t;

  logic clk = 1'b0;
  logic rst;

  drd_in_if  in_ch ();
  drd_out_if out_ch ();
  drd_cfg_if cfg_ch ();

  decrypt_rle_decimal_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  always #2 clk = ~clk;

  // decoder model state and register copies
  logic [drd_pkg::ROT_W-1:0]  rot_amt;
  logic [drd_pkg::BYTE_W-1:0] key_byte;
  logic [6:0]                 run_cnt;
  bit                         digit_pending;
  bit                         msg_error;

  result_t expected_results[$];
  result_t head_result;
  int      fail_count;
  int      items_sent;
  int      quiet_cycles;
  int      in_idle_pct;
  int      out_stall_pct;

  step_t directed_steps [25] = '{
    '{drd_pkg::CMD_END, 8'hFF, 1'b1, drd_pkg::STATUS_OK},     // empty message
    '{drd_pkg::CMD_RUN, "3",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_RUN, "A",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_RUN, "6",   1'b0, drd_pkg::STATUS_BYTE},   // longest run of zero bytes
    '{drd_pkg::CMD_RUN, "4",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_RUN, 8'h00, 1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_END, 8'hFF, 1'b1, drd_pkg::STATUS_OK},
    '{drd_pkg::CMD_RUN, "0",   1'b0, drd_pkg::STATUS_BYTE},   // zero count
    '{drd_pkg::CMD_RUN, "B",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_END, 8'h00, 1'b1, drd_pkg::STATUS_OK},
    '{drd_pkg::CMD_RUN, "C",   1'b0, drd_pkg::STATUS_BYTE},   // symbol without count
    '{drd_pkg::CMD_RUN, "5",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_RUN, "D",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_END, 8'h00, 1'b1, drd_pkg::STATUS_ERR},
    '{drd_pkg::CMD_RUN, "6",   1'b0, drd_pkg::STATUS_BYTE},   // count above max run
    '{drd_pkg::CMD_RUN, "5",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_END, 8'h00, 1'b1, drd_pkg::STATUS_ERR},
    '{drd_pkg::CMD_RUN, "7",   1'b0, drd_pkg::STATUS_BYTE},   // end after digits
    '{drd_pkg::CMD_END, 8'hFF, 1'b1, drd_pkg::STATUS_ERR},
    '{drd_pkg::CMD_RUN, "1",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_RUN, 8'hFF, 1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_RUN, "0",   1'b0, drd_pkg::STATUS_BYTE},   // leading zero
    '{drd_pkg::CMD_RUN, "2",   1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_RUN, 8'h80, 1'b0, drd_pkg::STATUS_BYTE},
    '{drd_pkg::CMD_END, 8'h00, 1'b1, drd_pkg::STATUS_OK}
  };

  logic [drd_pkg::ROT_W-1:0]  phase_rot [NUM_PHASES] = '{3'd0, 3'd7, 3'd3, 3'd7, 3'd1, 3'd0,
                                                         3'd5, 3'd6};
  logic [drd_pkg::BYTE_W-1:0] phase_key [NUM_PHASES] = '{8'h00, 8'hFF, 8'hA5, 8'h00, 8'h5A,
                                                         8'hFF, 8'h00, 8'h00};

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [drd_pkg::BYTE_W-1:0] decrypt_byte(
      input logic [drd_pkg::BYTE_W-1:0] cipher);
    logic [drd_pkg::BYTE_W-1:0] v;
    logic [drd_pkg::BYTE_W-1:0] r;
    v = cipher ^ key_byte;
    r = (v >> rot_amt) | (v << (8 - rot_amt));
    return r;
  endfunction

  function automatic logic [drd_pkg::BYTE_W-1:0] encrypt_byte(
      input logic [drd_pkg::BYTE_W-1:0] plain);
    logic [drd_pkg::BYTE_W-1:0] v;
    v = (plain << rot_amt) | (plain >> (8 - rot_amt));
    return v ^ key_byte;
  endfunction

  function automatic void decode_item(input drd_pkg::cmd_kind_t kind,
                                      input logic [drd_pkg::BYTE_W-1:0] cipher,
                                      output result_t produced[$]);
    logic [drd_pkg::BYTE_W-1:0] plain;
    int unsigned                acc;
    produced = {};
    if (kind == drd_pkg::CMD_END) begin
      produced.push_back('{(msg_error || digit_pending) ? drd_pkg::STATUS_ERR
                                                         : drd_pkg::STATUS_OK, 8'h00, 1'b1});
      run_cnt       = '0;
      digit_pending = 1'b0;
      msg_error     = 1'b0;
      return;
    end
    if (msg_error) return;
    plain = decrypt_byte(cipher);
    if (plain >= drd_pkg::CHAR_ZERO && plain <= drd_pkg::CHAR_NINE) begin
      acc = run_cnt * 10 + (plain - drd_pkg::CHAR_ZERO);
      digit_pending = 1'b1;
      if (acc > drd_pkg::MAX_RUN) begin
        msg_error = 1'b1;
        run_cnt   = '0;
      end else begin
        run_cnt = acc[6:0];
      end
      return;
    end
    if (!digit_pending) begin
      msg_error = 1'b1;
      return;
    end
    for (int k = 0; k < run_cnt; k++) begin
      produced.push_back('{drd_pkg::STATUS_BYTE, plain, (k + 1 == run_cnt)});
    end
    run_cnt       = '0;
    digit_pending = 1'b0;
  endfunction

  task automatic send_item(input drd_pkg::cmd_kind_t kind,
                           input logic [drd_pkg::BYTE_W-1:0] cipher,
                           input bit typed, input drd_pkg::status_t typed_status);
    result_t produced[$];
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= kind;
    in_ch.data_byte <= cipher;
    do @(posedge clk); while (!in_ch.ready);
    decode_item(kind, cipher, produced);
    if (typed) begin
      produced.delete();
      produced.push_back('{typed_status, 8'h00, 1'b1});
    end
    foreach (produced[i]) expected_results.push_back(produced[i]);
    items_sent++;
  endtask

  task automatic send_plain(input logic [drd_pkg::BYTE_W-1:0] plain);
    send_item(drd_pkg::CMD_RUN, encrypt_byte(plain), 1'b0, drd_pkg::STATUS_BYTE);
  endtask

  task automatic send_end();
    send_item(drd_pkg::CMD_END, 8'($urandom_range(255)), 1'b0, drd_pkg::STATUS_BYTE);
  endtask

  task automatic send_count(input int count);
    int digits[$];
    int c;
    c = count;
    if (c == 0) digits.push_back(0);
    while (c > 0) begin
      digits.push_front(c % 10);
      c = c / 10;
    end
    if ($urandom_range(4) == 0) digits.push_front(0);
    foreach (digits[i]) send_plain(drd_pkg::CHAR_ZERO + 8'(digits[i]));
  endtask

  function automatic logic [drd_pkg::BYTE_W-1:0] random_symbol();
    logic [drd_pkg::BYTE_W-1:0] sym;
    do sym = 8'($urandom_range(255));
    while (sym >= drd_pkg::CHAR_ZERO && sym <= drd_pkg::CHAR_NINE);
    return sym;
  endfunction

  function automatic int random_count();
    int w;
    w = $urandom_range(99);
    if (w < 10) return 0;
    if (w < 65) return $urandom_range(9, 1);
    if (w < 85) return $urandom_range(30, 10);
    if (w < 95) return $urandom_range(64, 31);
    return $urandom_range(250, 65);
  endfunction

  task automatic run_messages(input int target);
    int pairs;
    int pick;
    while (items_sent < target) begin
      pairs = $urandom_range(4);
      for (int p = 0; p < pairs; p++) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          send_count(random_count());
          send_plain(random_symbol());
        end else if (pick < 85) begin
          send_item(drd_pkg::CMD_RUN, 8'($urandom_range(255)), 1'b0, drd_pkg::STATUS_BYTE);
        end else if (pick < 93) begin
          send_plain(random_symbol());
        end else begin
          send_count($urandom_range(9));
        end
      end
      send_end();
    end
  endtask

  task automatic write_reg(input drd_pkg::reg_index_t idx,
                           input logic [drd_pkg::BYTE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      drd_pkg::REG_ROTATE: rot_amt  = value[drd_pkg::ROT_W-1:0];
      drd_pkg::REG_XOR:    key_byte = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [drd_pkg::ROT_W-1:0] rot,
                          input logic [drd_pkg::BYTE_W-1:0] key);
    write_reg(drd_pkg::REG_ROTATE, {5'($urandom_range(31)), rot});
    write_reg(drd_pkg::REG_XOR, key);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_mode(input int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 57; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 57; end
      default: begin in_idle_pct = 18; out_stall_pct = 18; end
    endcase
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d byte %02h last %0b",
                                  out_ch.status, out_ch.out_byte, out_ch.run_last));
      end else begin
        head_result = expected_results.pop_front();
        if (out_ch.status !== head_result.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, head_result.status));
        if (out_ch.out_byte !== head_result.sym)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte,
                                    head_result.sym));
        if (out_ch.run_last !== head_result.last)
          report_mismatch($sformatf("run_last %0b, want %0b", out_ch.run_last,
                                    head_result.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("decrypt_rle_decimal_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    items_sent    = 0;
    rot_amt       = '0;
    key_byte      = '0;
    run_cnt       = '0;
    digit_pending = 1'b0;
    msg_error     = 1'b0;
    set_mode(3);
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= drd_pkg::CMD_RUN;
    in_ch.data_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= drd_pkg::REG_ROTATE;
    cfg_ch.data     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      send_item(directed_steps[i].kind, encrypt_byte(directed_steps[i].plain),
                directed_steps[i].typed, directed_steps[i].typed_status);
    end
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_regs(phase_rot[p], (p >= 6) ? 8'($urandom_range(255)) : phase_key[p]);
      set_mode(p % 4);
      run_messages(items_sent + PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("decrypt_rle_decimal_decoder regression: pass");
    end else begin
      $display("decrypt_rle_decimal_decoder regression: fail");
    end
    $finish;
  end

endmodule
